FILE: rtl/csvft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
package csvft_pkg;

	localparam logic [7:0] QUOTE_CHAR  = 8'h22;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] TAB_CHAR    = 8'h09;
	localparam logic [7:0] DELIM_RESET = 8'h3B;

	typedef enum logic [2:0] {
		MODE_START      = 3'd0,
		MODE_PLAIN      = 3'd1,
		MODE_QUOTED     = 3'd2,
		MODE_QUOTE_SEEN = 3'd3,
		MODE_DISCARD    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FLUSH = 2'd1,
		PH_TAIL  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_end;
		logic [6:0] field_capacity;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       field_done;
		logic       run_last;
	} out_item_t;

	// Results of one input byte that follow the released whitespace.
	typedef struct packed {
		logic       has_byte;
		logic [7:0] data_byte;
		logic [1:0] done_cnt;
	} plan_t;

endpackage

FILE: rtl/csv_field_tokenizer_top.sv
// Streaming CSV field tokenizer: one byte in per transaction, field bytes and
// end-of-field marks out. Quoted fields may hold the delimiter, a doubled quote
// gives one quote, text after the closing quote is dropped, spaces and tabs
// around a field are trimmed, and a field keeps at most field_capacity - 1
// bytes, with field_capacity clamped to 1..MAX_FIELD_BYTES. With the output
// not stalled, an input byte is taken every cycle while each byte makes at
// most one result; a byte that makes more results, or that releases held
// whitespace, stalls input until its last result is loaded. Held whitespace
// goes out first, through registered reads of the held-whitespace buffer,
// replayed one entry per cycle while input is stalled and the output is not.
// The output is registered, so an input byte may be taken while the previous
// result is still stalled.
module csv_field_tokenizer_top import csvft_pkg::*; #(
	parameter int MAX_FIELD_BYTES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int HW = $clog2(MAX_FIELD_BYTES);
	localparam int AW = (MAX_FIELD_BYTES-1 > 1) ? $clog2(MAX_FIELD_BYTES-1) : 1;

	logic          take_ok, accept;
	plan_t         plan;
	logic [HW-1:0] flush_n;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;

	assign in_stall = !take_ok;
	assign accept   = in_valid && take_ok;

	csvft_parse #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept   (accept),
		.in_data  (in_data),
		.plan     (plan),
		.flush_n  (flush_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	csvft_held_mem #(
		.DEPTH(MAX_FIELD_BYTES - 1),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	csvft_emit #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.plan     (plan),
		.flush_n  (flush_n),
		.take_ok  (take_ok),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

FILE: rtl/csvft_held_mem.sv
// Held-whitespace buffer: one write port, one registered read port.
module csvft_held_mem import csvft_pkg::*; #(
	parameter int DEPTH = 63,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/csvft_parse.sv
// Field parser: mode and counters, per-byte decision and buffer writes.
module csvft_parse import csvft_pkg::*; #(
	parameter int MAX_FIELD_BYTES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [7:0]                         cfg_wdata,
	input  logic                               accept,
	input  in_item_t                           in_data,
	output plan_t                              plan,
	output logic [$clog2(MAX_FIELD_BYTES)-1:0] flush_n,
	output logic                               wr_en,
	output logic [((MAX_FIELD_BYTES-1 > 1) ? $clog2(MAX_FIELD_BYTES-1) : 1)-1:0] wr_addr,
	output logic [7:0]                         wr_data
);

	localparam int HW = $clog2(MAX_FIELD_BYTES);
	localparam int AW = (MAX_FIELD_BYTES-1 > 1) ? $clog2(MAX_FIELD_BYTES-1) : 1;
	localparam logic [HW-1:0] HELD_DEPTH = HW'(MAX_FIELD_BYTES - 1);
	localparam logic [6:0]    CAP_MAX    = 7'(MAX_FIELD_BYTES);

	logic [7:0]    delim_q;
	mode_t         mode_q, mode_d;
	logic [HW-1:0] kept_q, kept_d;
	logic [HW-1:0] held_q, held_d;
	logic          seen_q, seen_d;

	logic [7:0] b;
	logic [6:0] cap_c, limit;
	logic       is_sp, is_quote, is_delim, full;
	logic       do_end, do_content, do_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_we) begin
			delim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			kept_q <= '0;
			held_q <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			kept_q <= kept_d;
			held_q <= held_d;
			seen_q <= seen_d;
		end
	end

	always_comb begin
		b = in_data.in_byte;
		cap_c = in_data.field_capacity;
		if (cap_c == 7'd0) begin
			cap_c = 7'd1;
		end else if (cap_c > CAP_MAX) begin
			cap_c = CAP_MAX;
		end
		limit    = cap_c - 7'd1;
		is_sp    = (b == SPACE_CHAR) || (b == TAB_CHAR);
		is_quote = (b == QUOTE_CHAR);
		is_delim = (b == delim_q);
		full     = (7'(kept_q) >= limit);

		mode_d     = mode_q;
		do_end     = 1'b0;
		do_content = 1'b0;
		do_space   = 1'b0;

		unique case (mode_q)
			MODE_PLAIN: begin
				if (is_delim) begin
					do_end = 1'b1;
				end else if (full) begin
					mode_d = MODE_DISCARD;
				end else begin
					do_space   = is_sp;
					do_content = !is_sp;
				end
			end
			MODE_QUOTED: begin
				if (full) begin
					if (is_delim) begin
						do_end = 1'b1;
					end else begin
						mode_d = MODE_DISCARD;
					end
				end else if (is_quote) begin
					mode_d = MODE_QUOTE_SEEN;
				end else begin
					do_space   = is_sp;
					do_content = !is_sp;
				end
			end
			MODE_QUOTE_SEEN: begin
				if (is_quote) begin
					if (!full) begin
						do_content = 1'b1;
						mode_d     = MODE_QUOTED;
					end else begin
						mode_d = MODE_DISCARD;
					end
				end else if (is_delim) begin
					do_end = 1'b1;
				end else begin
					mode_d = MODE_DISCARD;
				end
			end
			MODE_DISCARD: begin
				if (is_delim) begin
					do_end = 1'b1;
				end
			end
			default: begin
				// Field start: whitespace, then quote, then delimiter, then a content byte.
				if (is_sp) begin
					mode_d = MODE_START;
				end else if (is_quote) begin
					mode_d = MODE_QUOTED;
				end else if (is_delim) begin
					do_end = 1'b1;
				end else if (!full) begin
					do_content = 1'b1;
					mode_d     = MODE_PLAIN;
				end else begin
					mode_d = MODE_DISCARD;
				end
			end
		endcase

		kept_d  = kept_q;
		held_d  = held_q;
		seen_d  = seen_q;
		plan    = '0;
		flush_n = '0;
		wr_en   = 1'b0;
		wr_addr = held_q[AW-1:0];
		wr_data = b;

		if (do_space) begin
			// Hold whitespace only once the field has content and while the buffer has room.
			if (seen_q && (held_q != HELD_DEPTH)) begin
				wr_en  = accept;
				held_d = held_q + 1'b1;
			end
			kept_d = kept_q + 1'b1;
		end
		if (do_content) begin
			flush_n        = held_q;
			held_d         = '0;
			plan.has_byte  = 1'b1;
			plan.data_byte = b;
			kept_d         = kept_q + 1'b1;
			seen_d         = 1'b1;
		end
		if (do_end || in_data.line_end) begin
			mode_d = MODE_START;
			held_d = '0;
			kept_d = '0;
			seen_d = 1'b0;
		end
		plan.done_cnt = 2'(do_end) + 2'(in_data.line_end);
	end

endmodule

FILE: rtl/csvft_emit.sv
// Result sequencer: releases held whitespace from the buffer, then the tail results.
module csvft_emit import csvft_pkg::*; #(
	parameter int MAX_FIELD_BYTES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  plan_t                              plan,
	input  logic [$clog2(MAX_FIELD_BYTES)-1:0] flush_n,
	output logic                               take_ok,
	output logic                               rd_en,
	output logic [((MAX_FIELD_BYTES-1 > 1) ? $clog2(MAX_FIELD_BYTES-1) : 1)-1:0] rd_addr,
	input  logic [7:0]                         rd_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output out_item_t                          out_data
);

	localparam int HW = $clog2(MAX_FIELD_BYTES);
	localparam int AW = (MAX_FIELD_BYTES-1 > 1) ? $clog2(MAX_FIELD_BYTES-1) : 1;

	phase_t        phase_q, phase_d;
	plan_t         tail_q, tail_d;
	logic [HW-1:0] ptr_q, ptr_d;
	logic [HW-1:0] cnt_q, cnt_d;
	logic          rd_valid_s1, rd_valid_d;
	logic          out_valid_q;
	out_item_t     out_data_q;

	logic      load, emit, last;
	out_item_t emit_data;

	assign load = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tail_q      <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			tail_q      <= tail_d;
			ptr_q       <= ptr_d;
			cnt_q       <= cnt_d;
			rd_valid_s1 <= rd_valid_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= emit_data;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		tail_d     = tail_q;
		ptr_d      = ptr_q;
		cnt_d      = cnt_q;
		rd_valid_d = rd_valid_s1;
		rd_en      = 1'b0;
		rd_addr    = ptr_q[AW-1:0];
		emit       = 1'b0;
		emit_data  = '0;
		last       = 1'b0;
		take_ok    = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				take_ok = 1'b1;
			end
			PH_FLUSH: begin
				if (!rd_valid_s1) begin
					rd_en      = 1'b1;
					ptr_d      = ptr_q + 1'b1;
					rd_valid_d = 1'b1;
				end else if (load) begin
					emit               = 1'b1;
					emit_data.out_byte = rd_data;
					// Issue the next read only as the current byte leaves.
					if (ptr_q != cnt_q) begin
						rd_en = 1'b1;
						ptr_d = ptr_q + 1'b1;
					end else begin
						rd_valid_d = 1'b0;
						phase_d    = PH_TAIL;
					end
				end
			end
			PH_TAIL: begin
				if (load) begin
					emit = 1'b1;
					if (tail_q.has_byte) begin
						emit_data.out_byte = tail_q.data_byte;
						last               = (tail_q.done_cnt == 2'd0);
						tail_d.has_byte    = 1'b0;
					end else begin
						emit_data.field_done = 1'b1;
						last                 = (tail_q.done_cnt == 2'd1);
						tail_d.done_cnt      = tail_q.done_cnt - 2'd1;
					end
					emit_data.run_last = last;
					if (last) begin
						phase_d = PH_IDLE;
						take_ok = 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (accept) begin
			tail_d = plan;
			if (flush_n != '0) begin
				phase_d    = PH_FLUSH;
				ptr_d      = '0;
				cnt_d      = flush_n;
				rd_valid_d = 1'b0;
			end else if (plan.has_byte || (plan.done_cnt != 2'd0)) begin
				phase_d = PH_TAIL;
			end else begin
				phase_d = PH_IDLE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/csvft_checker.sv
// Port-level checks for the CSV field tokenizer, bound to the top level.
module csvft_checker import csvft_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// Hold a stalled result transaction.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.field_done |-> out_data.out_byte == 8'h00)
		else $error("end-of-field result carries a byte");

	// Released whitespace always precedes the content byte that released it.
	a_last_not_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.field_done && out_data.run_last |->
			out_data.out_byte != SPACE_CHAR && out_data.out_byte != TAB_CHAR)
		else $error("whitespace ends a run");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind csv_field_tokenizer_top csvft_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
